// ----- src/utf8_to_utf16_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_macros.svh
// Assertion macros used by the decoder top level.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  localparam logic [ByteW-1:0] LeadMin  = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Max = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Max = 8'hEF;

  localparam logic [UnitW-1:0] SurrHiBase = 16'hD800;
  localparam logic [UnitW-1:0] SurrLoBase = 16'hDC00;
  localparam logic [CpW-1:0]   PlaneOne   = 21'h010000;
  localparam logic [CpW-1:0]   BmpMax     = 21'h00FFFF;

  // Units caused by one byte: none, one plain unit, or a surrogate pair.
  typedef struct packed {
    logic             has_unit;
    logic             pair;
    logic [UnitW-1:0] hi;
    logic [UnitW-1:0] lo;
  } emit_t;

  // One buffered code unit with its last flag.
  typedef struct packed {
    logic [UnitW-1:0] code;
    logic             last;
  } unit_t;

endpackage

// ----- src/u8u16_byte_if.sv -----
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Input channel carrying one UTF-8 byte per item.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// ----- src/u8u16_unit_if.sv -----
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Output channel carrying one UTF-16 code unit per item.
// ----------------------------------------------------------------------------
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last;

  modport source (output valid, output code_unit, output last, input ready);
  modport sink (input valid, input code_unit, input last, output ready);
endinterface

// ----- src/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// Next-state and emission logic for one UTF-8 byte.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic [7:0]             byte_i,
  input  logic [20:0]            acc_i,
  input  logic [1:0]             pend_i,
  output logic [20:0]            acc_o,
  output logic [1:0]             pend_o,
  output u8u16_pkg::emit_t       emit_o
);
  import u8u16_pkg::*;

  logic           complete;
  logic [CpW-1:0] v;

  always_comb begin
    complete = 1'b0;
    acc_o    = acc_i;
    pend_o   = pend_i;
    if (byte_i < LeadMin) begin
      if (pend_i != '0) begin
        acc_o    = {acc_i[CpW-7:0], byte_i[5:0]};
        pend_o   = pend_i - 2'd1;
        complete = (pend_i == 2'd1);
      end else begin
        acc_o    = {{(CpW-ByteW){1'b0}}, byte_i};
        complete = 1'b1;
      end
    end else if (byte_i <= Lead2Max) begin
      acc_o  = {{(CpW-5){1'b0}}, byte_i[4:0]};
      pend_o = 2'd1;
    end else if (byte_i <= Lead3Max) begin
      acc_o  = {{(CpW-4){1'b0}}, byte_i[3:0]};
      pend_o = 2'd2;
    end else begin
      acc_o  = {{(CpW-3){1'b0}}, byte_i[2:0]};
      pend_o = 2'd3;
    end
  end

  assign v = acc_o - PlaneOne;

  always_comb begin
    emit_o.has_unit = complete && (acc_o != '0);
    emit_o.pair     = acc_o > BmpMax;
    emit_o.hi       = SurrHiBase + {5'b0, v[20:10]};
    emit_o.lo       = emit_o.pair ? (SurrLoBase + {6'b0, v[9:0]}) : acc_o[UnitW-1:0];
  end

endmodule

// ----- src/utf8_to_utf16_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Converts a UTF-8 byte stream into UTF-16 code units without validation.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                    Item
// byte_i    in   byte_in[7:0]               one UTF-8 byte
// unit_o    out  code_unit[15:0], last      one UTF-16 code unit
//
// A byte is registered on entry, decoded in the next cycle and its units are
// written to a two-entry result buffer.
// One byte is taken per cycle while the result buffer has room for its units; the
// buffer absorbs the second unit of a surrogate pair, so the input stalls only after the receiver has held ready low.
// Bytes that complete no code point pass the result buffer even while it
// is stalled. Reset clears the decoder state, the input valid flag and the
// unit count.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_macros.svh"

module utf8_to_utf16_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  u8u16_byte_if.sink          byte_i,
  u8u16_unit_if.source        unit_o
);
  import u8u16_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic [CpW-1:0]   acc_q, acc_d;
  logic [PendW-1:0] pend_q, pend_d;
  emit_t            emit;

  unit_t            slot0_q, slot0_d;
  unit_t            slot1_q, slot1_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       keep_cnt;

  logic fits;
  logic advance;
  logic in_take;
  logic out_take;
  logic head_hi;
  logic hi_in_range;
  logic hi_taken;

  u8u16_decode u_decode (
    .byte_i (in_byte_q),
    .acc_i  (acc_q),
    .pend_i (pend_q),
    .acc_o  (acc_d),
    .pend_o (pend_d),
    .emit_o (emit)
  );

  assign out_take = (cnt_q != 2'd0) && unit_o.ready;
  assign keep_cnt = cnt_q - {1'b0, out_take};
  assign fits     = emit.pair ? (keep_cnt == 2'd0) : (keep_cnt != 2'd2);
  assign advance  = in_valid_q && (!emit.has_unit || fits);
  assign byte_i.ready = !in_valid_q || advance;
  assign in_take  = byte_i.valid && byte_i.ready;

  assign unit_o.valid     = (cnt_q != 2'd0);
  assign unit_o.code_unit = slot0_q.code;
  assign unit_o.last      = slot0_q.last;

  assign head_hi     = unit_o.valid && !slot0_q.last;
  assign hi_in_range = (slot0_q.code[15:11] == 5'b11011);
  assign hi_taken    = out_take && !slot0_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.byte_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
    end else if (advance) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    cnt_d   = keep_cnt;
    slot0_d = out_take ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    if (advance && emit.has_unit) begin
      if (emit.pair) begin
        slot0_d = '{code: emit.hi, last: 1'b0};
        slot1_d = '{code: emit.lo, last: 1'b1};
        cnt_d   = 2'd2;
      end else if (keep_cnt == 2'd0) begin
        slot0_d = '{code: emit.lo, last: 1'b1};
        cnt_d   = 2'd1;
      end else begin
        slot1_d = '{code: emit.lo, last: 1'b1};
        cnt_d   = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  `U8U16_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3, "unit count out of range")
  `U8U16_ASSERT_NOW(a_hi_range, clk_i, rst_ni, head_hi, hi_in_range, "high unit out of range")
  `U8U16_ASSERT_NEXT(a_low_follows, clk_i, rst_ni, hi_taken, !head_hi && unit_o.valid, "low unit missing")

endmodule

// ----- verif/utf8_to_utf16_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_test
// Self-checking testbench for the UTF-8 to UTF-16 decoder. A short table of
// directed bytes comes first, then random well-formed sequences mixed with
// noise and broken sequences, under three mixes of sender and receiver
// stalls. Every code unit is checked against a predictor or the directed table.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_test;
  import u8u16_pkg::*;

  localparam int NumDirected   = 24;
  localparam int BytesPerPhase = 640;
  localparam int StallLimit    = 4000;
  localparam int TailCycles    = 16;
  localparam int ErrShowMax    = 40;

  typedef struct packed {
    logic [1:0]       count;
    logic [UnitW-1:0] first;
    logic [UnitW-1:0] second;
  } units_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_val;
    logic             typed;
    units_t           want;
  } stim_row_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last;
  } unit_exp_t;

  localparam stim_row_t DirRows [NumDirected] = '{
    '{8'h00, 1'b1, '{2'd0, 16'h0000, 16'h0000}},
    '{8'h41, 1'b1, '{2'd1, 16'h0041, 16'h0000}},
    '{8'h80, 1'b1, '{2'd1, 16'h0080, 16'h0000}},
    '{8'hBF, 1'b1, '{2'd1, 16'h00BF, 16'h0000}},
    '{8'hE2, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'hAC, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'h9F, 1'b0, '0},
    '{8'h98, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hF4, 1'b0, '0},
    '{8'h8F, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b1, '{2'd2, 16'hDBFF, 16'hDFFF}},
    '{8'hFF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hE2, 1'b0, '0},
    '{8'hC2, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h80, 1'b1, '{2'd0, 16'h0000, 16'h0000}}
  };

  logic clk_i;
  logic rst_ni;

  u8u16_byte_if byte_if ();
  u8u16_unit_if unit_if ();

  utf8_to_utf16_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .unit_o (unit_if)
  );

  logic [CpW-1:0]   cp_acc    = '0;
  logic [PendW-1:0] cont_left = '0;
  unit_exp_t        units_due [$];
  unit_exp_t        head;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          bytes_sent;
  int          units_checked = 0;
  int          err_count     = 0;
  int          quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic units_t code_point_units(input logic [CpW-1:0] cp);
    units_t         u;
    logic [CpW-1:0] off;
    u   = '0;
    off = cp - PlaneOne;
    if (cp == '0) begin
      u.count = 2'd0;
    end else if (cp <= BmpMax) begin
      u.count = 2'd1;
      u.first = cp[UnitW-1:0];
    end else begin
      u.count  = 2'd2;
      u.first  = UnitW'(off[CpW-1:10]) + SurrHiBase;
      u.second = UnitW'(off[9:0]) + SurrLoBase;
    end
    return u;
  endfunction

  function automatic units_t decode_utf8_byte(input logic [ByteW-1:0] b);
    units_t u;
    u = '0;
    if (b < LeadMin) begin
      if (cont_left != '0) begin
        cp_acc    = {cp_acc[CpW-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == '0) begin
          u = code_point_units(cp_acc);
        end
      end else begin
        cp_acc = CpW'(b);
        u      = code_point_units(cp_acc);
      end
    end else if (b <= Lead2Max) begin
      cont_left = 2'd1;
      cp_acc    = CpW'(b[4:0]);
    end else if (b <= Lead3Max) begin
      cont_left = 2'd2;
      cp_acc    = CpW'(b[3:0]);
    end else begin
      cont_left = 2'd3;
      cp_acc    = CpW'(b[2:0]);
    end
    return u;
  endfunction

  function automatic void queue_units(input units_t u);
    if (u.count != 2'd0) begin
      units_due.push_back('{u.first, u.count == 2'd1});
    end
    if (u.count == 2'd2) begin
      units_due.push_back('{u.second, 1'b1});
    end
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed, input units_t want);
    units_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid   <= 1'b0;
      byte_if.byte_in <= ByteW'($urandom);
      @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.byte_in <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    got = decode_utf8_byte(b);
    queue_units(typed ? want : got);
    bytes_sent++;
  endtask

  task automatic send_random_item();
    int unsigned    roll;
    int unsigned    n;
    logic [CpW-1:0] cp;
    roll = $urandom_range(99);
    if (roll < 80) begin
      case ($urandom_range(3))
        0:       cp = CpW'($urandom_range(127));
        1:       cp = CpW'($urandom_range('h80, 'h7FF));
        2:       cp = CpW'($urandom_range('h800, 'hFFFF));
        default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (cp < 'h80) begin
        send_byte(cp[7:0], 1'b0, '0);
      end else if (cp < 'h800) begin
        send_byte({3'b110, cp[10:6]}, 1'b0, '0);
        send_byte({2'b10, cp[5:0]}, 1'b0, '0);
      end else if (cp < 'h10000) begin
        send_byte({4'b1110, cp[15:12]}, 1'b0, '0);
        send_byte({2'b10, cp[11:6]}, 1'b0, '0);
        send_byte({2'b10, cp[5:0]}, 1'b0, '0);
      end else begin
        send_byte({5'b11110, cp[20:18]}, 1'b0, '0);
        send_byte({2'b10, cp[17:12]}, 1'b0, '0);
        send_byte({2'b10, cp[11:6]}, 1'b0, '0);
        send_byte({2'b10, cp[5:0]}, 1'b0, '0);
      end
    end else if (roll < 90) begin
      send_byte(ByteW'($urandom_range(255)), 1'b0, '0);
    end else begin
      send_byte(ByteW'($urandom_range('hC0, 'hFF)), 1'b0, '0);
      n = $urandom_range(2);
      repeat (n) send_byte(ByteW'($urandom_range('h80, 'hBF)), 1'b0, '0);
    end
  endtask

  task automatic drain_pause();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (units_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      unit_if.ready <= 1'b0;
    end else begin
      if (unit_if.valid && unit_if.ready) begin
        units_checked++;
        if (units_due.size() == 0) begin
          err_count++;
          if (err_count <= ErrShowMax) begin
            $display("%0t: expected no unit, actual code_unit %h last %b",
                     $time, unit_if.code_unit, unit_if.last);
          end
        end else begin
          head = units_due.pop_front();
          if (unit_if.code_unit !== head.code_unit) begin
            err_count++;
            if (err_count <= ErrShowMax) begin
              $display("%0t: code_unit expected %h actual %h",
                       $time, head.code_unit, unit_if.code_unit);
            end
          end
          if (unit_if.last !== head.last) begin
            err_count++;
            if (err_count <= ErrShowMax) begin
              $display("%0t: last expected %b actual %b", $time, head.last, unit_if.last);
            end
          end
        end
      end
      unit_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (unit_if.valid && unit_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int directed_bytes;
    int phase_start;
    rst_ni          <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.byte_in <= '0;
    send_idle_pct   = 36;
    recv_idle_pct   = 81;
    bytes_sent      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_byte(DirRows[i].byte_val, DirRows[i].typed, DirRows[i].want);
    end
    drain_pause();
    directed_bytes = bytes_sent;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerPhase) begin
        send_random_item();
      end
      drain_pause();
    end

    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes (%0d directed), checked %0d code units.",
             bytes_sent, directed_bytes, units_checked);
    $display("Covered 1- to 4-byte sequences, surrogate pairs, restarts, truncation and noise.");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/u8u16_pkg.sv
src/u8u16_byte_if.sv
src/u8u16_unit_if.sv
src/u8u16_decode.sv
src/utf8_to_utf16_decoder.sv
verif/utf8_to_utf16_decoder_test.sv
